// ----- src/bpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bpsd_pkg
// Shared types, codes and sizes of the bmp pixel stream decoder.
// ----------------------------------------------------------------------------
package bpsd_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;

   localparam int CFG_DIM_W   = 9;
   localparam int LIM_W       = $clog2(MAX_WIDTH + 1);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int HLIM_W      = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int ADDR_W      = 16;
   localparam int PIX_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_4BPP  = 2'd0;
   localparam logic [1:0] MODE_24BPP = 2'd1;
   localparam logic [1:0] MODE_32BPP = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH_MODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TOP_DOWN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TRANSP      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_NIBBLE_MAP  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CHAN_ORDER  = 3'd6;

   localparam logic [7:0] ALPHA_LIMIT = 8'h80;

   typedef enum logic [1:0] {
      STATUS_STORED      = 2'd0,
      STATUS_NEED_TRANSP = 2'd1,
      STATUS_COLLIDE     = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]           depth_mode;
      logic [CFG_DIM_W-1:0] image_width;
      logic [CFG_DIM_W-1:0] image_height;
      logic                 top_down;
      logic [PIX_W-1:0]     transparent_color;
      logic [63:0]          nibble_remap;
      logic [7:0]           channel_order;
   } cfg_type;

   typedef struct packed {
      logic             is_nibble;
      logic [ROW_W-1:0] row_base;
      logic [COL_W-1:0] column;
      logic [LIM_W-1:0] limit;
      logic [PIX_W-1:0] value;
      status_type       status;
      logic             last;
      logic [PIX_W-1:0] returned_color;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- src/bpsd_req_if.sv -----
// ----------------------------------------------------------------------------
// bpsd_req_if
// Input channel: one pixel data byte per transaction.
// ----------------------------------------------------------------------------
interface bpsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ----- src/bpsd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bpsd_rsp_if
// Result channel: one buffer write or abort report per transaction.
// ----------------------------------------------------------------------------
interface bpsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] write_address;
   logic [15:0] pixel_value;
   logic [1:0]  status;
   logic        last;
   logic [15:0] returned_color;

   modport source (output valid, output write_address, output pixel_value,
                   output status, output last, output returned_color, input ready);
   modport sink   (input valid, input write_address, input pixel_value,
                   input status, input last, input returned_color, output ready);
endinterface

// ----- src/bpsd_front.sv -----
// ----------------------------------------------------------------------------
// bpsd_front
// Accepts bytes, tracks phase, padding, column and row, gathers pixels,
// decides aborts and pushes one operation per result into the queue.
// ----------------------------------------------------------------------------
module bpsd_front (
   input  logic               clock,
   input  logic               reset,
   input  bpsd_pkg::cfg_type  cfg,
   bpsd_req_if.sink           req,
   input  logic               q_full,
   output logic               q_push,
   output bpsd_pkg::op_type   q_op
);

   logic [1:0]                  phase_ff, phase_in;
   logic [23:0]                 gath_ff, gath_in;
   logic [bpsd_pkg::COL_W-1:0]  col_ff, col_in;
   logic [bpsd_pkg::HLIM_W-1:0] row_ff, row_in;
   logic [1:0]                  pad_ff, pad_in;
   logic                        halted_ff, halted_in;

   logic                        accept;
   logic                        halt_e;
   logic [1:0]                  phase_e, pad_e;
   logic [23:0]                 gath_e;
   logic [bpsd_pkg::COL_W-1:0]  col_e;
   logic [bpsd_pkg::HLIM_W-1:0] row_e, row_next;
   logic [bpsd_pkg::LIM_W-1:0]  w, limit, col_next;
   logic [bpsd_pkg::HLIM_W-1:0] h;
   logic                        is4, is24;
   logic [1:0]                  pad;
   logic [2:0]                  need;
   logic [7:0]                  b;
   logic [7:0]                  bytes [4];
   logic [7:0]                  chan [4];
   logic [15:0]                 col565;
   logic [15:0]                 val;
   bpsd_pkg::status_type        status;
   logic [15:0]                 ret;
   logic                        emit, last;
   logic [bpsd_pkg::ROW_W-1:0]  row_base;
   logic [bpsd_pkg::PIX_W-1:0]  tc;

   assign accept    = req.valid && req.ready;
   assign req.ready = !q_full;
   assign b         = req.data_byte;
   assign tc        = cfg.transparent_color;

   always_comb begin
      w = (cfg.image_width == '0) ? bpsd_pkg::LIM_W'(1) :
          (int'(cfg.image_width) > bpsd_pkg::MAX_WIDTH) ?
          bpsd_pkg::LIM_W'(bpsd_pkg::MAX_WIDTH) : bpsd_pkg::LIM_W'(cfg.image_width);
      h = (cfg.image_height == '0) ? bpsd_pkg::HLIM_W'(1) :
          (int'(cfg.image_height) > bpsd_pkg::MAX_HEIGHT) ?
          bpsd_pkg::HLIM_W'(bpsd_pkg::MAX_HEIGHT) : bpsd_pkg::HLIM_W'(cfg.image_height);
      is4  = (cfg.depth_mode == bpsd_pkg::MODE_4BPP);
      is24 = (cfg.depth_mode == bpsd_pkg::MODE_24BPP);
      need = is24 ? 3'd3 : 3'd4;

      limit = is4 ? bpsd_pkg::LIM_W'(({1'b0, w} + 1'b1) >> 1) : w;
      if (is4) begin
         pad = 2'(2'd0 - limit[1:0]);
      end else if (is24) begin
         pad = w[1:0];
      end else begin
         pad = 2'd0;
      end

      halt_e  = req.frame_start ? 1'b0 : halted_ff;
      phase_e = req.frame_start ? 2'd0 : phase_ff;
      gath_e  = req.frame_start ? 24'd0 : gath_ff;
      col_e   = req.frame_start ? '0 : col_ff;
      row_e   = req.frame_start ? '0 : row_ff;
      pad_e   = req.frame_start ? 2'd0 : pad_ff;

      row_base = cfg.top_down ? bpsd_pkg::ROW_W'(row_e) :
                 bpsd_pkg::ROW_W'(h - 1'b1 - row_e);

      // pixel assembly
      bytes[0] = gath_e[7:0];
      bytes[1] = gath_e[15:8];
      bytes[2] = is24 ? b : gath_e[23:16];
      bytes[3] = b;
      for (int k = 0; k < 4; k++) begin
         chan[k] = 8'h00;
      end
      if (is24) begin
         chan[0] = b;
         chan[1] = bytes[1];
         chan[2] = bytes[0];
         chan[3] = 8'hFF;
      end else begin
         for (int k = 0; k < 4; k++) begin
            chan[cfg.channel_order[2*k +: 2]] = bytes[k];
         end
      end
      col565 = {chan[0][7:3], chan[1][7:2], chan[2][7:3]};

      status = bpsd_pkg::STATUS_STORED;
      ret    = 16'd0;
      if (chan[3] > bpsd_pkg::ALPHA_LIMIT) begin
         val = col565;
         if (tc != '0 && col565 == tc) begin
            status = bpsd_pkg::STATUS_COLLIDE;
            ret    = 16'(tc + 1'b1);
         end
      end else begin
         val = tc;
         if (tc == '0) begin
            status = bpsd_pkg::STATUS_NEED_TRANSP;
            ret    = 16'd1;
         end
      end
      if (is4) begin
         val    = {8'h00, b};
         status = bpsd_pkg::STATUS_STORED;
         ret    = 16'd0;
      end

      col_next = bpsd_pkg::LIM_W'({1'b0, col_e} + 1'b1);
      row_next = bpsd_pkg::HLIM_W'(row_e + 1'b1);

      halted_in = halt_e;
      phase_in  = phase_e;
      gath_in   = gath_e;
      col_in    = col_e;
      row_in    = row_e;
      pad_in    = pad_e;
      emit      = 1'b0;
      last      = 1'b0;

      priority if (halt_e) begin
      end else if (pad_e != 2'd0) begin
         pad_in = 2'(pad_e - 1'b1);
      end else if (row_e >= h) begin
         halted_in = 1'b1;
      end else if (!is4 && ({1'b0, phase_e} + 3'd1 < need)) begin
         gath_in  = gath_e | (24'(b) << {phase_e, 3'b000});
         phase_in = 2'(phase_e + 1'b1);
      end else begin
         emit = 1'b1;
         // nibble bytes leave the pixel gather untouched
         if (!is4) begin
            phase_in = 2'd0;
            gath_in  = 24'd0;
         end
         if (status != bpsd_pkg::STATUS_STORED) begin
            halted_in = 1'b1;
            last      = 1'b1;
            val       = 16'd0;
         end else if (col_next >= limit) begin
            col_in = '0;
            row_in = row_next;
            pad_in = pad;
            if (row_next >= h) begin
               halted_in = 1'b1;
               last      = 1'b1;
               ret       = tc;
            end
         end else begin
            col_in = bpsd_pkg::COL_W'(col_next);
         end
      end
   end

   always_comb begin
      q_push              = accept && emit;
      q_op.is_nibble      = is4;
      q_op.row_base       = row_base;
      q_op.column         = col_e;
      q_op.limit          = limit;
      q_op.value          = val;
      q_op.status         = status;
      q_op.last           = last;
      q_op.returned_color = ret;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 2'd0;
         gath_ff   <= 24'd0;
         col_ff    <= '0;
         row_ff    <= '0;
         pad_ff    <= 2'd0;
         halted_ff <= 1'b1;
      end else if (accept) begin
         phase_ff  <= phase_in;
         gath_ff   <= gath_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// ----- src/bpsd_queue.sv -----
// ----------------------------------------------------------------------------
// bpsd_queue
// Short operation queue between the front and the back.
// ----------------------------------------------------------------------------
module bpsd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bpsd_pkg::op_type       push_op,
   input  logic                   pop,
   output bpsd_pkg::op_type       head_op,
   output bpsd_pkg::q_status_type status
);

   bpsd_pkg::op_type              entry_ff [bpsd_pkg::QUEUE_DEPTH];
   logic [bpsd_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bpsd_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bpsd_pkg::QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? bpsd_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? bpsd_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = bpsd_pkg::QCNT_W'(count_ff + bpsd_pkg::QCNT_W'(push)
                                             - bpsd_pkg::QCNT_W'(pop));
      status.full  = (count_ff == bpsd_pkg::QCNT_W'(bpsd_pkg::QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      head_op      = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/bpsd_back.sv -----
// ----------------------------------------------------------------------------
// bpsd_back
// Pops operations, forms the buffer address and the nibble-remapped value,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module bpsd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bpsd_pkg::cfg_type      cfg,
   input  bpsd_pkg::op_type       head_op,
   input  bpsd_pkg::q_status_type q_status,
   output logic                   pop,
   bpsd_rsp_if.source             rsp
);

   logic                         valid_ff;
   logic [bpsd_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [bpsd_pkg::PIX_W-1:0]   value_ff, value_in;
   logic [1:0]                   status_ff;
   logic                         last_ff;
   logic [bpsd_pkg::PIX_W-1:0]   ret_ff;

   function automatic logic [3:0] remap(input logic [63:0] map, input logic [3:0] n);
      return map[{n, 2'b00} +: 4];
   endfunction

   always_comb begin
      pop     = !q_status.empty && (!valid_ff || rsp.ready);
      addr_in = bpsd_pkg::ADDR_W'(bpsd_pkg::ADDR_W'(head_op.row_base)
                                  * bpsd_pkg::ADDR_W'(head_op.limit)
                                  + bpsd_pkg::ADDR_W'(head_op.column));
      if (head_op.is_nibble) begin
         value_in = {8'h00, remap(cfg.nibble_remap, head_op.value[7:4]),
                     remap(cfg.nibble_remap, head_op.value[3:0])};
      end else begin
         value_in = head_op.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         addr_ff   <= addr_in;
         value_ff  <= value_in;
         status_ff <= head_op.status;
         last_ff   <= head_op.last;
         ret_ff    <= head_op.returned_color;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.write_address  = addr_ff;
   assign rsp.pixel_value    = value_ff;
   assign rsp.status         = status_ff;
   assign rsp.last           = last_ff;
   assign rsp.returned_color = ret_ff;

endmodule

// ----- src/bmp_pixel_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder
// Turns the pixel bytes of one bmp frame into rgb565 or nibble buffer writes.
// ----------------------------------------------------------------------------
// Takes one pixel data byte per cycle, back to back, at every depth, as long
// as the four-entry operation queue has room; the front updates its counters
// once per accepted byte. Bytes that gather a pixel, row padding and bytes
// after the frame has ended or aborted give no response. A response passes
// through the queue entry, then the output register where the address
// multiply is taken. Frame_start on a byte clears all counters and the halt.
// Registers take effect at once and are to be written while idle.
module bmp_pixel_stream_decoder (
   input  logic                                clock,
   input  logic                                reset,
   bpsd_req_if.sink                            req_chan,
   bpsd_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [bpsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   bpsd_pkg::cfg_type      cfg_ff, cfg_in;
   logic                   q_push, q_pop;
   bpsd_pkg::op_type       q_op, head_op;
   bpsd_pkg::q_status_type q_stat;
   logic                   req_acc;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bpsd_pkg::REG_DEPTH_MODE: cfg_in.depth_mode        = csr_wdata[1:0];
            bpsd_pkg::REG_WIDTH:      cfg_in.image_width       = csr_wdata[8:0];
            bpsd_pkg::REG_HEIGHT:     cfg_in.image_height      = csr_wdata[8:0];
            bpsd_pkg::REG_TOP_DOWN:   cfg_in.top_down          = csr_wdata[0];
            bpsd_pkg::REG_TRANSP:     cfg_in.transparent_color = csr_wdata[15:0];
            bpsd_pkg::REG_NIBBLE_MAP: cfg_in.nibble_remap      = csr_wdata[63:0];
            bpsd_pkg::REG_CHAN_ORDER: cfg_in.channel_order     = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode        <= bpsd_pkg::MODE_24BPP;
         cfg_ff.image_width       <= 9'd80;
         cfg_ff.image_height      <= 9'd64;
         cfg_ff.top_down          <= 1'b0;
         cfg_ff.transparent_color <= 16'h0000;
         cfg_ff.nibble_remap      <= 64'hFEDC_BA98_7654_3210;
         cfg_ff.channel_order     <= 8'hC6;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpsd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_chan),
      .q_full (q_stat.full),
      .q_push (q_push),
      .q_op   (q_op)
   );

   bpsd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_op),
      .pop     (q_pop),
      .head_op (head_op),
      .status  (q_stat)
   );

   bpsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_op  (head_op),
      .q_status (q_stat),
      .pop      (q_pop),
      .rsp      (rsp_chan)
   );

   assign req_acc = req_chan.valid && req_chan.ready;

   // no push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("operation pushed into full queue");

   // after the final or aborting result, bytes give nothing until frame start
   a_halt_after_last: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_op.last) |=> ((req_acc && !req_chan.frame_start) |-> !q_push))
      else $error("result produced after frame end");

   // a waiting queue entry reaches an empty output register next cycle
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_chan.valid && !q_stat.empty) |=> rsp_chan.valid)
      else $error("queued operation not moved to output");

endmodule
